// ===== rtl/btr_pkg.sv =====
package btr_pkg;

    localparam int PEN_W    = 17;
    localparam int COORD_W  = 12;
    localparam int SIDE_W   = 5;
    localparam int COLOR_W  = 32;
    localparam int CODE_W   = 8;
    localparam int DOTS     = 25;
    localparam int SUM_W    = PEN_W + 1;

    localparam logic [PEN_W-1:0] PEN_X_MAX = {PEN_W{1'b1}};
    localparam logic [2:0]       LAST_COL  = 3'd4;
    localparam logic [2:0]       ADVANCE   = 3'd6;

    typedef struct packed {
        logic [CODE_W-1:0]  char_code;
        logic               first;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [SIDE_W-1:0]  scale;
        logic [COLOR_W-1:0] color;
    } char_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] rect_x;
        logic [COORD_W-1:0] rect_y;
        logic [SIDE_W-1:0]  rect_side;
        logic [COLOR_W-1:0] fill_color;
        logic               clamped;
        logic               last;
    } rect_item_t;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic glyph_empty;
        logic dot_lit;
        logic rest_empty;
        logic out_free;
    } dp_status_t;

    // rows 0..4 packed from the top, column 0 in the msb of each row
    function automatic logic [DOTS-1:0] glyph_bits(input logic [CODE_W-1:0] code);
        logic [DOTS-1:0] bits;
        case (code)
            8'h41: bits = {5'h0E, 5'h11, 5'h1F, 5'h11, 5'h11};
            8'h42: bits = {5'h1E, 5'h11, 5'h1E, 5'h11, 5'h1E};
            8'h43: bits = {5'h0E, 5'h10, 5'h10, 5'h10, 5'h0E};
            8'h44: bits = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E};
            8'h45: bits = {5'h1F, 5'h10, 5'h1E, 5'h10, 5'h1F};
            8'h46: bits = {5'h1F, 5'h10, 5'h1E, 5'h10, 5'h10};
            8'h47: bits = {5'h0F, 5'h10, 5'h17, 5'h11, 5'h0F};
            8'h48: bits = {5'h11, 5'h11, 5'h1F, 5'h11, 5'h11};
            8'h49: bits = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h1F};
            8'h4C: bits = {5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            8'h4D: bits = {5'h11, 5'h1B, 5'h15, 5'h11, 5'h11};
            8'h4F: bits = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
            8'h50: bits = {5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10};
            8'h52: bits = {5'h1E, 5'h11, 5'h1E, 5'h12, 5'h11};
            8'h53: bits = {5'h0E, 5'h10, 5'h0E, 5'h01, 5'h1E};
            8'h54: bits = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04};
            8'h55: bits = {5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            8'h56: bits = {5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
            8'h58: bits = {5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11};
            8'h5A: bits = {5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F};
            8'h61: bits = {5'h00, 5'h0C, 5'h12, 5'h12, 5'h0F};
            8'h62: bits = {5'h10, 5'h10, 5'h1C, 5'h12, 5'h1C};
            8'h63: bits = {5'h00, 5'h0C, 5'h10, 5'h10, 5'h0C};
            8'h64: bits = {5'h02, 5'h02, 5'h0E, 5'h12, 5'h0E};
            8'h65: bits = {5'h00, 5'h0C, 5'h12, 5'h1C, 5'h0C};
            8'h66: bits = {5'h0C, 5'h08, 5'h1C, 5'h08, 5'h08};
            8'h67: bits = {5'h00, 5'h0E, 5'h12, 5'h0F, 5'h01};
            8'h68: bits = {5'h10, 5'h10, 5'h1C, 5'h12, 5'h12};
            8'h69: bits = {5'h08, 5'h00, 5'h08, 5'h08, 5'h08};
            8'h6C: bits = {5'h08, 5'h08, 5'h08, 5'h08, 5'h08};
            8'h6D: bits = {5'h00, 5'h1A, 5'h15, 5'h15, 5'h15};
            8'h6E: bits = {5'h00, 5'h1C, 5'h12, 5'h12, 5'h12};
            8'h6F: bits = {5'h00, 5'h0C, 5'h12, 5'h12, 5'h0C};
            8'h70: bits = {5'h00, 5'h1C, 5'h12, 5'h1C, 5'h10};
            8'h72: bits = {5'h00, 5'h14, 5'h1C, 5'h10, 5'h10};
            8'h73: bits = {5'h00, 5'h0E, 5'h18, 5'h06, 5'h1C};
            8'h74: bits = {5'h08, 5'h1C, 5'h08, 5'h08, 5'h0C};
            8'h75: bits = {5'h00, 5'h12, 5'h12, 5'h12, 5'h0E};
            8'h76: bits = {5'h00, 5'h00, 5'h11, 5'h0A, 5'h04};
            8'h77: bits = {5'h00, 5'h11, 5'h11, 5'h15, 5'h0A};
            8'h79: bits = {5'h00, 5'h12, 5'h12, 5'h0E, 5'h02};
            8'h2E: bits = {5'h00, 5'h00, 5'h00, 5'h00, 5'h04};
            8'h3A: bits = {5'h00, 5'h04, 5'h00, 5'h04, 5'h00};
            8'h2D: bits = {5'h00, 5'h00, 5'h0E, 5'h00, 5'h00};
            8'h2F: bits = {5'h01, 5'h02, 5'h04, 5'h08, 5'h10};
            8'h28: bits = {5'h04, 5'h08, 5'h08, 5'h08, 5'h04};
            8'h29: bits = {5'h04, 5'h02, 5'h02, 5'h02, 5'h04};
            8'h30: bits = {5'h0E, 5'h13, 5'h15, 5'h19, 5'h0E};
            8'h31: bits = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h0E};
            8'h32: bits = {5'h1E, 5'h01, 5'h0E, 5'h10, 5'h1F};
            8'h33: bits = {5'h1E, 5'h01, 5'h0E, 5'h01, 5'h1E};
            8'h34: bits = {5'h11, 5'h11, 5'h1F, 5'h01, 5'h01};
            8'h35: bits = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h1E};
            8'h36: bits = {5'h0E, 5'h10, 5'h1E, 5'h11, 5'h0E};
            8'h37: bits = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h04};
            8'h38: bits = {5'h0E, 5'h11, 5'h0E, 5'h11, 5'h0E};
            8'h39: bits = {5'h0E, 5'h11, 5'h0F, 5'h01, 5'h0E};
            default: bits = '0;
        endcase
        return bits;
    endfunction

endpackage

// ===== rtl/btr_stream_if.sv =====
interface btr_char_if
    import btr_pkg::*;
();
    logic       valid;
    logic       ready;
    char_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface btr_rect_if
    import btr_pkg::*;
();
    logic       valid;
    logic       ready;
    rect_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/btr_ctrl.sv =====
module btr_ctrl
    import btr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic state_reg;
    logic state_next;

    assign char_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        cmd.emit   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = char_valid;
                // blank or unknown glyphs never leave idle
                if (char_valid && !status.glyph_empty)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // a lit dot waits for room in the output register
                cmd.step = !status.dot_lit || status.out_free;
                cmd.emit = cmd.step && status.dot_lit;
                if (cmd.step && status.rest_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/btr_datapath.sv =====
module btr_datapath
    import btr_pkg::*;
#(
    parameter int MAX_SCALE = 16,
    parameter int COORD_MAX = 4095
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_cmd_t  cmd,
    input  char_item_t char_item,
    output dp_status_t status,
    output logic       rect_valid,
    output rect_item_t rect_item,
    input  logic       rect_ready
);

    localparam int SC_W  = $clog2(MAX_SCALE + 1);
    localparam int CMP_W = (SC_W > SIDE_W) ? SC_W : SIDE_W;
    localparam int OFF_W = $clog2(4 * MAX_SCALE + 1);
    localparam int ADV_W = $clog2(6 * MAX_SCALE + 1);

    localparam logic [CMP_W-1:0] SC_LIMIT = CMP_W'(MAX_SCALE);
    localparam logic [SUM_W-1:0] CMAX     = SUM_W'(COORD_MAX);

    logic [DOTS-1:0]    mask_reg,   mask_next;
    logic [PEN_W-1:0]   pen_x_reg,  pen_x_next;
    logic [COORD_W-1:0] pen_y_reg,  pen_y_next;
    logic [PEN_W-1:0]   base_x_reg, base_x_next;
    logic [SC_W-1:0]    sc_reg,     sc_next;
    logic [COLOR_W-1:0] color_reg,  color_next;
    logic [2:0]         col_reg,    col_next;
    logic [OFF_W-1:0]   col_off_reg, col_off_next;
    logic [OFF_W-1:0]   row_off_reg, row_off_next;
    logic               rect_valid_reg, rect_valid_next;
    rect_item_t         rect_reg,   rect_next;

    logic [DOTS-1:0]    glyph;
    logic [CMP_W-1:0]   sc_in;
    logic [ADV_W-1:0]   advance;
    logic [SUM_W-1:0]   pen_sum;
    logic [SUM_W-1:0]   x_sum;
    logic [SUM_W-1:0]   y_sum;
    logic               hit_x;
    logic               hit_y;

    assign glyph = glyph_bits(char_item.char_code);

    assign status.glyph_empty = (glyph == '0);
    assign status.dot_lit     = mask_reg[DOTS-1];
    assign status.rest_empty  = (mask_reg[DOTS-2:0] == '0);
    assign status.out_free    = !rect_valid_reg || rect_ready;

    always_comb
    begin
        sc_in = CMP_W'(char_item.scale);
        if (sc_in == '0)
        begin
            sc_in = CMP_W'(1);
        end
        else if (sc_in > SC_LIMIT)
        begin
            sc_in = SC_LIMIT;
        end
    end

    // pen advance of six dots, saturating at the top of the pen range
    assign advance = ADV_W'(sc_next) * ADV_W'(ADVANCE);
    assign pen_sum = SUM_W'(base_x_next) + SUM_W'(advance);

    assign x_sum = SUM_W'(base_x_reg) + SUM_W'(col_off_reg);
    assign y_sum = SUM_W'(pen_y_reg) + SUM_W'(row_off_reg);
    assign hit_x = (x_sum > CMAX);
    assign hit_y = (y_sum > CMAX);

    always_comb
    begin
        mask_next       = mask_reg;
        pen_x_next      = pen_x_reg;
        pen_y_next      = pen_y_reg;
        base_x_next     = base_x_reg;
        sc_next         = sc_reg;
        color_next      = color_reg;
        col_next        = col_reg;
        col_off_next    = col_off_reg;
        row_off_next    = row_off_reg;
        rect_next       = rect_reg;
        rect_valid_next = rect_valid_reg;

        if (cmd.load)
        begin
            sc_next      = SC_W'(sc_in);
            color_next   = char_item.color;
            mask_next    = glyph;
            col_next     = '0;
            col_off_next = '0;
            row_off_next = '0;
            if (char_item.first)
            begin
                base_x_next = PEN_W'(char_item.start_x);
                pen_y_next  = char_item.start_y;
            end
            else
            begin
                base_x_next = pen_x_reg;
            end
            pen_x_next = (pen_sum > SUM_W'(PEN_X_MAX)) ? PEN_X_MAX : pen_sum[PEN_W-1:0];
        end
        else if (cmd.step)
        begin
            mask_next = mask_reg << 1;
            if (col_reg == LAST_COL)
            begin
                col_next     = '0;
                col_off_next = '0;
                row_off_next = row_off_reg + OFF_W'(sc_reg);
            end
            else
            begin
                col_next     = col_reg + 3'd1;
                col_off_next = col_off_reg + OFF_W'(sc_reg);
            end
        end

        if (cmd.emit)
        begin
            rect_valid_next      = 1'b1;
            rect_next.rect_x     = hit_x ? CMAX[COORD_W-1:0] : x_sum[COORD_W-1:0];
            rect_next.rect_y     = hit_y ? CMAX[COORD_W-1:0] : y_sum[COORD_W-1:0];
            rect_next.rect_side  = SIDE_W'(sc_reg);
            rect_next.fill_color = color_reg;
            rect_next.clamped    = hit_x || hit_y;
            rect_next.last       = status.rest_empty;
        end
        else if (rect_ready)
        begin
            rect_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg       <= '0;
            pen_x_reg      <= '0;
            pen_y_reg      <= '0;
            col_reg        <= '0;
            rect_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg       <= mask_next;
            pen_x_reg      <= pen_x_next;
            pen_y_reg      <= pen_y_next;
            col_reg        <= col_next;
            rect_valid_reg <= rect_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_x_reg  <= base_x_next;
        sc_reg      <= sc_next;
        color_reg   <= color_next;
        col_off_reg <= col_off_next;
        row_off_reg <= row_off_next;
        rect_reg    <= rect_next;
    end

    assign rect_valid = rect_valid_reg;
    assign rect_item  = rect_reg;

    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!rect_valid_reg || rect_ready))
        else $error("rect emitted over an unread item");

    a_step_needs_dots: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (mask_reg != '0))
        else $error("scan step with no dots left");

    a_last_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && status.rest_empty) |=> (mask_reg == '0) && rect_item.last)
        else $error("last rect left dots behind");

    a_load_clears_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (col_reg == '0) && (col_off_reg == '0) && (row_off_reg == '0))
        else $error("scan position not cleared on load");

endmodule

// ===== rtl/bitmap_text_rect_rasterizer_unit.sv =====
// 5x5 bitmap text rasterizer
// char_in takes one character per item: code, a first flag that loads the
// pen from start_x/start_y, a dot scale (0 reads as 1, large values saturate
// at MAX_SCALE) and a 32-bit color. rect_out gives one square fill rectangle
// per lit glyph dot, row by row and left to right, with last marking the
// final rectangle of a character. Coordinates above COORD_MAX are clamped
// and flagged. The pen moves right by six dots after every character.
// Timing: a character is loaded into the glyph mask register, then the
// scanner walks the glyph one dot per cycle, unless a lit dot waits for
// room in the output register, and stops after the last lit dot; unknown
// and blank characters give nothing and leave the unit ready. The first
// rectangle passes the mask register and then the output register, each
// unlit dot ahead of it delaying it by a scan step. The next character is
// taken as soon as the scan of the current one ends, even while its last
// rectangle still waits in the output register.
// Reset puts the pen at (0, 0) and empties the output register. When the
// receiver stalls, the scan holds on the next lit dot and char_in stays
// not ready until the scan can finish.
module bitmap_text_rect_rasterizer_unit
    import btr_pkg::*;
#(
    parameter int MAX_SCALE = 16,
    parameter int COORD_MAX = 4095
)
(
    input  logic              clk,
    input  logic              rst_n,
    btr_char_if.sink          char_in,
    btr_rect_if.source        rect_out
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       char_ready;
    logic       rect_valid;
    rect_item_t rect_item;

    btr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_in.valid),
        .char_ready (char_ready),
        .status     (status),
        .cmd        (cmd)
    );

    btr_datapath #(
        .MAX_SCALE (MAX_SCALE),
        .COORD_MAX (COORD_MAX)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .char_item  (char_in.payload),
        .status     (status),
        .rect_valid (rect_valid),
        .rect_item  (rect_item),
        .rect_ready (rect_out.ready)
    );

    assign char_in.ready    = char_ready;
    assign rect_out.valid   = rect_valid;
    assign rect_out.payload = rect_item;

endmodule
